FILE: rtl/msbr_pkg.sv
// Shared types and constants of the mirrored scrolling bar renderer.
package msbr_pkg;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANGE_LOW  = 3'd0,
    CFG_RANGE_HIGH = 3'd1,
    CFG_BLEND      = 3'd2,
    CFG_CENTER     = 3'd3,
    CFG_PEAK       = 3'd4,
    CFG_BASE       = 3'd5,
    CFG_BACKGROUND = 3'd6
  } cfg_reg_e;

  // Register values after reset.
  localparam logic signed [15:0] RangeLowRst   = 16'sd0;
  localparam logic signed [15:0] RangeHighRst  = 16'sd100;
  localparam logic               BlendRst      = 1'b0;
  localparam logic [15:0]        CenterRst     = 16'h0000;
  localparam logic [15:0]        PeakRst       = 16'hFFFF;
  localparam logic [15:0]        BaseRst       = 16'h07E0;
  localparam logic [15:0]        BackgroundRst = 16'h0000;

  // Kind of an input request.
  localparam logic KindPush = 1'b0;
  localparam logic KindRead = 1'b1;

  // Divide-by-255 with rounding: (s * MixMul) >> MixShift.
  localparam logic [15:0] MixMul   = 16'h8081;
  localparam int          MixShift = 23;
  localparam int          MixSumW  = 14;
  localparam int          MixProdW = 30;

  // Quotient bits of the blend ratio.
  localparam int RatioW = 8;

endpackage

FILE: rtl/msbr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module msbr_div #(
  parameter int NW = 26,
  parameter int DW = 16,
  parameter int QW = 10,
  parameter int SW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [SW-1:0] steps_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quotient_o
);

  logic          busy_q;
  logic          done_q;
  logic [SW-1:0] cnt_q;
  logic [NW-1:0] rem_q;
  logic [NW-1:0] dsr_q;
  logic [QW-1:0] quo_q;
  logic          ge;

  // The remainder is at least the aligned divisor: this quotient bit is one.
  assign ge = (rem_q >= dsr_q);

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - SW'(1);
        if (cnt_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder, aligned divisor and quotient.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsr_q <= NW'(divisor_i) << (steps_i - SW'(1));
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsr_q;
      end
      dsr_q <= dsr_q >> 1;
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/mirrored_scrolling_bar_renderer_unit.sv
// Top level of the mirrored scrolling bar renderer.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, kind, sample,      | request in
//           | column, row                               |
//   out     | out_valid_o/out_ready_i, pixel_color      | result out
//   cfg     | cfg_valid_i/cfg_ready_o, index, data      | write in
//
// One request at a time; the next is taken in the idle cycle after it. A push divides
// the scaled sample by the range into HW bits, HW being the bit count of HEIGHT/2
// (7 at the default size), unless the sample clamps. A read skips the divider for an
// unwritten column or a background or base pixel; a blend takes RatioW (8) bits.
// Reset clears the ring pointer and fill count; no clearing pass is needed.
// A finished read waits in the output register; a later read stalls until it drains.
module mirrored_scrolling_bar_renderer_unit
  import msbr_pkg::*;
#(
  parameter int WIDTH  = 256,
  parameter int HEIGHT = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic signed [31:0]  sample_i,
  input  logic [7:0]          column_i,
  input  logic [6:0]          row_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         pixel_color_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int Center = HEIGHT / 2;
  localparam int HW     = $clog2(Center + 1);
  localparam int ColW   = $clog2(WIDTH);
  localparam int FillW  = $clog2(WIDTH + 1);
  localparam int IdxW   = (ColW > 8) ? ColW : 8;
  localparam int SumW   = IdxW + 1;
  localparam int DistW  = ((HW > 7) ? HW : 7) + 1;
  localparam int QMW    = (HW > RatioW) ? HW : RatioW;
  localparam int NW     = 16 + QMW;
  localparam int SW     = $clog2(QMW + 1);
  localparam int ProdW  = 32 + HW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_PMUL, S_PDIV, S_PWR, S_RMEM, S_RDIV, S_MIX, S_SCALE, S_OUT
  } state_e;

  // Configuration registers.
  logic signed [15:0] range_low_q, range_high_q;
  logic               blend_q;
  logic [15:0]        center_q, peak_q, base_q, background_q;

  // Sequencer state and datapath registers.
  state_e              state_q;
  logic                kind_q;
  logic signed [31:0]  sample_q;
  logic [7:0]          col_q;
  logic [6:0]          row_q;
  logic [31:0]         num_q;
  logic [15:0]         range_q;
  logic [HW-1:0]       half_q;
  logic [HW-1:0]       dist_q;
  logic [RatioW-1:0]   ratio_q;
  logic [MixSumW-1:0]  sum_r_q, sum_g_q, sum_b_q;
  logic [15:0]         pix_q;
  logic                out_valid_q;
  logic [15:0]         out_pix_q;
  logic [ColW-1:0]     oldest_q;
  logic [FillW-1:0]    fill_q;

  // Column memory.
  logic [HW-1:0] mem [WIDTH];
  logic [HW-1:0] rd_q;
  logic          mem_we, mem_re;

  // Decode-stage signals.
  logic signed [33:0] num;
  logic signed [16:0] rng;
  logic [15:0]        rng_pos;
  logic signed [33:0] den;
  logic               oor;
  logic [SumW-1:0]    slot_sum;
  logic [ColW-1:0]    slot;
  logic               written;
  logic [DistW-1:0]   row_x, ctr_x, dist_full;

  // Divider hookup.
  logic             div_start;
  logic [SW-1:0]    div_steps;
  logic [NW-1:0]    div_dividend;
  logic [15:0]      div_divisor;
  logic             div_done;
  logic [QMW-1:0]   div_quo;
  logic [ProdW-1:0] prod;
  logic [HW+7:0]    dist255;

  // Blend signals.
  logic [4:0]          pk_r, pk_b, ct_r, ct_b;
  logic [5:0]          pk_g, ct_g;
  logic [RatioW-1:0]   inv_ratio;
  logic [MixProdW-1:0] scl_r, scl_g, scl_b;

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = out_pix_q;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RangeLowRst;
      range_high_q <= RangeHighRst;
      blend_q      <= BlendRst;
      center_q     <= CenterRst;
      peak_q       <= PeakRst;
      base_q       <= BaseRst;
      background_q <= BackgroundRst;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_RANGE_LOW:  range_low_q  <= $signed(cfg_data_i);
        CFG_RANGE_HIGH: range_high_q <= $signed(cfg_data_i);
        CFG_BLEND:      blend_q      <= cfg_data_i[0];
        CFG_CENTER:     center_q     <= cfg_data_i;
        CFG_PEAK:       peak_q       <= cfg_data_i;
        CFG_BASE:       base_q       <= cfg_data_i;
        CFG_BACKGROUND: background_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sample normalization: offset numerator and a range of at least one.
  assign num     = 34'(sample_q) - {{2{range_low_q[15]}}, range_low_q, 16'b0};
  assign rng     = {range_high_q[15], range_high_q} - {range_low_q[15], range_low_q};
  assign rng_pos = (rng > 17'sd0) ? rng[15:0] : 16'd1;
  assign den     = {2'b0, rng_pos, 16'b0};

  // Ring slot of the requested column and whether it was ever written.
  assign oor      = ({24'b0, col_q} >= 32'(WIDTH)) || ({25'b0, row_q} >= 32'(HEIGHT));
  assign slot_sum = (SumW'(oldest_q) + SumW'(col_q) >= SumW'(WIDTH)) ?
                    SumW'(oldest_q) + SumW'(col_q) - SumW'(WIDTH) :
                    SumW'(oldest_q) + SumW'(col_q);
  assign slot     = slot_sum[ColW-1:0];
  assign written  = (FillW'(slot) < fill_q);

  // Distance of the row from the mirror axis.
  assign row_x     = DistW'(row_q);
  assign ctr_x     = DistW'(Center);
  assign dist_full = (row_x >= ctr_x) ? row_x - ctr_x : ctr_x - row_x;

  // Divider operands: scaled sample over range, or distance * 255 over half.
  assign prod    = {{HW{1'b0}}, num_q} * {32'b0, HW'(Center)};
  assign dist255 = {dist_q, 8'b0} - (HW + 8)'(dist_q);

  always_comb begin
    div_start    = 1'b0;
    div_steps    = SW'(HW);
    div_dividend = NW'(prod[ProdW-1:16]);
    div_divisor  = range_q;
    if (state_q == S_PMUL) begin
      div_start = 1'b1;
    end else if (state_q == S_RMEM) begin
      div_start    = !(dist_q > rd_q) && blend_q && (rd_q != '0);
      div_steps    = SW'(RatioW);
      div_dividend = NW'(dist255);
      div_divisor  = 16'(rd_q);
    end
  end

  msbr_div #(
    .NW(NW),
    .DW(16),
    .QW(QMW),
    .SW(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Color channels and the rounded divide by 255.
  assign pk_r      = peak_q[15:11];
  assign pk_g      = peak_q[10:5];
  assign pk_b      = peak_q[4:0];
  assign ct_r      = center_q[15:11];
  assign ct_g      = center_q[10:5];
  assign ct_b      = center_q[4:0];
  assign inv_ratio = 8'd255 - ratio_q;
  assign scl_r     = MixProdW'(sum_r_q) * MixProdW'(MixMul);
  assign scl_g     = MixProdW'(sum_g_q) * MixProdW'(MixMul);
  assign scl_b     = MixProdW'(sum_b_q) * MixProdW'(MixMul);

  // Column memory: write on push, registered read on pixel read.
  assign mem_we = (state_q == S_PWR);
  assign mem_re = (state_q == S_DEC) && (kind_q == KindRead);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[oldest_q] <= half_q;
    end
    if (mem_re) begin
      rd_q <= mem[slot];
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= KindPush;
      sample_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      num_q       <= '0;
      range_q     <= '0;
      half_q      <= '0;
      dist_q      <= '0;
      ratio_q     <= '0;
      sum_r_q     <= '0;
      sum_g_q     <= '0;
      sum_b_q     <= '0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      oldest_q    <= '0;
      fill_q      <= '0;
    end else begin
      // The output state reloads the register itself when it hands over.
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            kind_q   <= kind_i;
            sample_q <= sample_i;
            col_q    <= column_i;
            row_q    <= row_i;
            state_q  <= S_DEC;
          end
        end
        S_DEC: begin
          if (kind_q == KindPush) begin
            num_q   <= num[31:0];
            range_q <= rng_pos;
            if (num <= 34'sd0) begin
              half_q  <= '0;
              state_q <= S_PWR;
            end else if (num >= den) begin
              half_q  <= HW'(Center);
              state_q <= S_PWR;
            end else begin
              state_q <= S_PMUL;
            end
          end else begin
            dist_q <= dist_full[HW-1:0];
            if (oor || !written) begin
              pix_q   <= background_q;
              state_q <= S_OUT;
            end else begin
              state_q <= S_RMEM;
            end
          end
        end
        S_PMUL: begin
          state_q <= S_PDIV;
        end
        S_PDIV: begin
          if (div_done) begin
            half_q  <= div_quo[HW-1:0];
            state_q <= S_PWR;
          end
        end
        S_PWR: begin
          oldest_q <= (oldest_q == ColW'(WIDTH - 1)) ? '0 : oldest_q + ColW'(1);
          if (fill_q != FillW'(WIDTH)) begin
            fill_q <= fill_q + FillW'(1);
          end
          state_q <= S_IDLE;
        end
        S_RMEM: begin
          if (dist_q > rd_q) begin
            pix_q   <= background_q;
            state_q <= S_OUT;
          end else if (!blend_q) begin
            pix_q   <= base_q;
            state_q <= S_OUT;
          end else if (rd_q == '0) begin
            ratio_q <= '0;
            state_q <= S_MIX;
          end else begin
            state_q <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            ratio_q <= div_quo[RatioW-1:0];
            state_q <= S_MIX;
          end
        end
        S_MIX: begin
          sum_r_q <= MixSumW'(pk_r) * MixSumW'(ratio_q) + MixSumW'(ct_r) * MixSumW'(inv_ratio)
                     + MixSumW'(128);
          sum_g_q <= MixSumW'(pk_g) * MixSumW'(ratio_q) + MixSumW'(ct_g) * MixSumW'(inv_ratio)
                     + MixSumW'(128);
          sum_b_q <= MixSumW'(pk_b) * MixSumW'(ratio_q) + MixSumW'(ct_b) * MixSumW'(inv_ratio)
                     + MixSumW'(128);
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          pix_q   <= {scl_r[MixShift+4:MixShift], scl_g[MixShift+5:MixShift],
                      scl_b[MixShift+4:MixShift]};
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Hand over once the output register is free or being drained.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= pix_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/msbr_chk.sv
// Port checker for the renderer top level, with its bind statement.
module msbr_chk
  import msbr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] pixel_color_o
);

  logic [2:0] owed_q;
  logic       rd_acc, out_acc;

  assign rd_acc  = in_valid_i && in_ready_o && (kind_i == KindRead);
  assign out_acc = out_valid_o && out_ready_i;

  // Count read requests whose pixel has not been delivered yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + {2'b0, rd_acc} - {2'b0, out_acc};
    end
  end

  // No result is offered without a read request behind it.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (owed_q != 3'd0))
    else $error("result offered without an outstanding read");

  // The unit works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted in back-to-back cycles");

  // Once reset has been seen at an edge, no result is shown.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A stalled result keeps its color.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(pixel_color_o)))
    else $error("stalled result changed");

endmodule

bind mirrored_scrolling_bar_renderer_unit msbr_chk u_msbr_chk (.*);
